@@ design/rational_arithmetic_unit_assert.svh @@
// Assertion macros shared by the rational arithmetic unit modules.
// Included by rau_ctrl and rau_dp; no other dependencies.
`ifndef RATIONAL_ARITHMETIC_UNIT_ASSERT_SVH
`define RATIONAL_ARITHMETIC_UNIT_ASSERT_SVH

// Same-cycle implication under synchronous reset.
`define RAU_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rational_arithmetic_unit: same-cycle check failed");

// Next-cycle implication under synchronous reset.
`define RAU_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rational_arithmetic_unit: next-cycle check failed");

`endif

@@ design/rau_pkg.sv @@
// Types and constants of the rational arithmetic unit.
// Used by rau_ctrl, rau_dp and rational_arithmetic_unit; no dependencies.
`default_nettype none

package rau_pkg;

   localparam int MAG_W = 64;   // exact magnitude width of intermediates
   localparam int CNT_W = 7;    // divider step counter
   localparam int SHF_W = 6;    // gcd common power of two

   localparam logic [2:0] CMD_ADD = 3'd0;
   localparam logic [2:0] CMD_SUB = 3'd1;
   localparam logic [2:0] CMD_MUL = 3'd2;
   localparam logic [2:0] CMD_DIV = 3'd3;

   typedef enum logic [4:0] {
      OP_NONE     = 5'd0,
      OP_LOAD     = 5'd1,
      OP_GCD_A    = 5'd2,
      OP_GCD_B    = 5'd3,
      OP_GCD_DEN  = 5'd4,
      OP_DIV_N0   = 5'd5,
      OP_DIV_D0   = 5'd6,
      OP_DIV_N1   = 5'd7,
      OP_DIV_D1   = 5'd8,
      OP_DIV_T    = 5'd9,
      OP_MUL_PROD = 5'd10,
      OP_MUL_XY   = 5'd11,
      OP_MUL_LCD  = 5'd12,
      OP_ADDSUB   = 5'd13,
      OP_OUT      = 5'd14
   } op_type;

   typedef struct packed {
      op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic       done;
      logic [2:0] command;
   } dp_stat_type;

endpackage

`default_nettype wire

@@ design/rau_dp.sv @@
// Datapath of the rational arithmetic unit: operand registers, binary gcd,
// restoring divider, 32x32 multipliers and result register. Uses rau_pkg.
`default_nettype none

module rau_dp #(
   parameter int WIDTH = 32
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire rau_pkg::dp_cmd_type cmd,
   output rau_pkg::dp_stat_type     stat,
   input  wire logic [2:0]          req_command,
   input  wire logic signed [31:0]  req_a_num,
   input  wire logic signed [31:0]  req_a_den,
   input  wire logic signed [31:0]  req_b_num,
   input  wire logic signed [31:0]  req_b_den,
   output logic signed [31:0]       rsp_res_num,
   output logic [30:0]              rsp_res_den,
   output logic                     rsp_overflow
);

`include "rational_arithmetic_unit_assert.svh"

   localparam int MW = rau_pkg::MAG_W;

   logic [MW-1:0] n0_ff, n0_in, d0_ff, d0_in, n1_ff, n1_in, d1_ff, d1_in;
   logic [MW-1:0] t_ff, t_in, g_ff, g_in;
   logic          s0_ff, s0_in, s1_ff, s1_in;
   logic [2:0]    cmd_ff, cmd_in;
   logic [MW-1:0] gx_ff, gx_in, gy_ff, gy_in;
   logic [rau_pkg::SHF_W-1:0] gk_ff, gk_in;
   logic          gcd_busy_ff, gcd_busy_in;
   logic [MW-1:0] rem_ff, rem_in, quo_ff, quo_in;
   logic [rau_pkg::CNT_W-1:0] dcnt_ff, dcnt_in;
   logic          div_busy_ff, div_busy_in;
   rau_pkg::op_type ddst_ff, ddst_in;
   logic          done_ff, done_in;
   logic signed [31:0] rnum_ff, rnum_in;
   logic [30:0]   rden_ff, rden_in;
   logic          rovf_ff, rovf_in;

   logic [MW:0]   shifted;
   logic          fits;
   logic [MW-1:0] lim_den, lim_num, neg_n0, signed_n0;

   function automatic logic [32:0] field_mag(input logic [31:0] v);
      logic signed [32:0] ext;
      ext = 33'($signed(v[WIDTH-1:0]));
      field_mag = ext[32] ? 33'(-ext) : 33'(ext);
   endfunction

   function automatic logic [MW-1:0] mul32(input logic [MW-1:0] a, input logic [MW-1:0] b);
      logic [31:0] a32, b32;
      a32 = a[31:0];
      b32 = b[31:0];
      mul32 = {32'd0, a32} * {32'd0, b32};
   endfunction

   assign shifted = {rem_ff, quo_ff[MW-1]};
   assign lim_den = (64'd1 << (WIDTH - 1)) - 64'd1;
   assign lim_num = s0_ff ? lim_den + 64'd1 : lim_den;
   assign fits    = (n0_ff <= lim_num) && (d0_ff <= lim_den);
   assign neg_n0  = 64'd0 - n0_ff;
   assign signed_n0 = s0_ff ? neg_n0 : n0_ff;

   always_comb begin
      logic bneg;
      n0_in = n0_ff; d0_in = d0_ff; n1_in = n1_ff; d1_in = d1_ff;
      t_in = t_ff; g_in = g_ff; s0_in = s0_ff; s1_in = s1_ff; cmd_in = cmd_ff;
      gx_in = gx_ff; gy_in = gy_ff; gk_in = gk_ff; gcd_busy_in = gcd_busy_ff;
      rem_in = rem_ff; quo_in = quo_ff; dcnt_in = dcnt_ff;
      div_busy_in = div_busy_ff; ddst_in = ddst_ff;
      rnum_in = rnum_ff; rden_in = rden_ff; rovf_in = rovf_ff;
      done_in = 1'b0;
      bneg = s1_ff ^ (cmd_ff == rau_pkg::CMD_SUB);

      // Binary gcd, one step per cycle; the common power of two returns at the end.
      if (gcd_busy_ff) begin
         if (gx_ff == '0 || gy_ff == '0) begin
            g_in = (gx_ff | gy_ff) << gk_ff;
            gcd_busy_in = 1'b0;
            done_in = 1'b1;
         end else if (!gx_ff[0] && !gy_ff[0]) begin
            gx_in = gx_ff >> 1;
            gy_in = gy_ff >> 1;
            gk_in = gk_ff + 1'b1;
         end else if (!gx_ff[0]) begin
            gx_in = gx_ff >> 1;
         end else if (!gy_ff[0]) begin
            gy_in = gy_ff >> 1;
         end else if (gx_ff >= gy_ff) begin
            gx_in = (gx_ff - gy_ff) >> 1;
         end else begin
            gy_in = (gy_ff - gx_ff) >> 1;
         end
      end

      // Restoring divider by the gcd, one quotient bit per cycle.
      if (div_busy_ff) begin
         if (shifted >= {1'b0, g_ff}) begin
            rem_in = MW'(shifted - {1'b0, g_ff});
            quo_in = {quo_ff[MW-2:0], 1'b1};
         end else begin
            rem_in = shifted[MW-1:0];
            quo_in = {quo_ff[MW-2:0], 1'b0};
         end
         dcnt_in = dcnt_ff + 1'b1;
         if (dcnt_ff == rau_pkg::CNT_W'(MW - 1)) begin
            div_busy_in = 1'b0;
            done_in = 1'b1;
            case (ddst_ff)
               rau_pkg::OP_DIV_N0: n0_in = quo_in;
               rau_pkg::OP_DIV_D0: d0_in = quo_in;
               rau_pkg::OP_DIV_N1: n1_in = quo_in;
               rau_pkg::OP_DIV_D1: d1_in = quo_in;
               default:            t_in  = quo_in;
            endcase
         end
      end

      case (cmd.op)
         rau_pkg::OP_LOAD: begin
            cmd_in = req_command;
            n0_in = MW'(field_mag(req_a_num));
            d0_in = MW'(field_mag(req_a_den));
            s0_in = req_a_num[WIDTH-1] ^ req_a_den[WIDTH-1];
            n1_in = MW'(field_mag(req_b_num));
            d1_in = MW'(field_mag(req_b_den));
            s1_in = req_b_num[WIDTH-1] ^ req_b_den[WIDTH-1];
            done_in = 1'b1;
         end
         rau_pkg::OP_GCD_A: begin
            if (n0_ff == '0 || d0_ff == '0) begin
               n0_in = '0; d0_in = 64'd1; s0_in = 1'b0; g_in = 64'd1;
               done_in = 1'b1;
            end else begin
               gx_in = n0_ff; gy_in = d0_ff; gk_in = '0; gcd_busy_in = 1'b1;
            end
         end
         rau_pkg::OP_GCD_B: begin
            if (n1_ff == '0 || d1_ff == '0) begin
               n1_in = '0; d1_in = 64'd1; s1_in = 1'b0; g_in = 64'd1;
               done_in = 1'b1;
            end else begin
               gx_in = n1_ff; gy_in = d1_ff; gk_in = '0; gcd_busy_in = 1'b1;
            end
         end
         rau_pkg::OP_GCD_DEN: begin
            gx_in = d0_ff; gy_in = d1_ff; gk_in = '0; gcd_busy_in = 1'b1;
         end
         rau_pkg::OP_DIV_N0, rau_pkg::OP_DIV_D0, rau_pkg::OP_DIV_N1,
         rau_pkg::OP_DIV_D1, rau_pkg::OP_DIV_T: begin
            case (cmd.op)
               rau_pkg::OP_DIV_N0: quo_in = n0_ff;
               rau_pkg::OP_DIV_D0: quo_in = d0_ff;
               rau_pkg::OP_DIV_N1: quo_in = n1_ff;
               default:            quo_in = d1_ff;
            endcase
            rem_in = '0; dcnt_in = '0; div_busy_in = 1'b1; ddst_in = cmd.op;
         end
         rau_pkg::OP_MUL_PROD: begin
            if (cmd_ff == rau_pkg::CMD_DIV) begin
               n0_in = mul32(n0_ff, d1_ff);
               d0_in = mul32(d0_ff, n1_ff);
            end else begin
               n0_in = mul32(n0_ff, n1_ff);
               d0_in = mul32(d0_ff, d1_ff);
            end
            s0_in = s0_ff ^ s1_ff;
            done_in = 1'b1;
         end
         rau_pkg::OP_MUL_XY: begin
            n0_in = mul32(n0_ff, t_ff);
            n1_in = mul32(n1_ff, d0_ff);
            done_in = 1'b1;
         end
         rau_pkg::OP_MUL_LCD: begin
            d0_in = mul32(d0_ff, d1_ff);
            done_in = 1'b1;
         end
         rau_pkg::OP_ADDSUB: begin
            if (s0_ff == bneg) begin
               n0_in = n0_ff + n1_ff;
            end else if (n0_ff >= n1_ff) begin
               n0_in = n0_ff - n1_ff;
            end else begin
               n0_in = n1_ff - n0_ff;
               s0_in = bneg;
            end
            done_in = 1'b1;
         end
         rau_pkg::OP_OUT: begin
            rnum_in = fits ? signed_n0[31:0] : 32'sd0;
            rden_in = fits ? d0_ff[30:0] : 31'd1;
            rovf_in = !fits;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      n0_ff <= n0_in; d0_ff <= d0_in; n1_ff <= n1_in; d1_ff <= d1_in;
      t_ff <= t_in; g_ff <= g_in; s0_ff <= s0_in; s1_ff <= s1_in; cmd_ff <= cmd_in;
      gx_ff <= gx_in; gy_ff <= gy_in; gk_ff <= gk_in;
      rem_ff <= rem_in; quo_ff <= quo_in; dcnt_ff <= dcnt_in; ddst_ff <= ddst_in;
      rnum_ff <= rnum_in; rden_ff <= rden_in; rovf_ff <= rovf_in;
      if (reset) begin
         gcd_busy_ff <= 1'b0;
         div_busy_ff <= 1'b0;
         done_ff     <= 1'b0;
      end else begin
         gcd_busy_ff <= gcd_busy_in;
         div_busy_ff <= div_busy_in;
         done_ff     <= done_in;
      end
   end

   assign stat.done    = done_ff;
   assign stat.command = cmd_ff;
   assign rsp_res_num  = rnum_ff;
   assign rsp_res_den  = rden_ff;
   assign rsp_overflow = rovf_ff;

   `RAU_ASSERT_IMPL(a_units_exclusive, clock, reset, gcd_busy_ff, !div_busy_ff)
   `RAU_ASSERT_NEXT(a_div_finishes, clock, reset,
      div_busy_ff && dcnt_ff == rau_pkg::CNT_W'(MW - 1), done_ff && !div_busy_ff)
   `RAU_ASSERT_NEXT(a_ovf_zero, clock, reset, cmd.op == rau_pkg::OP_OUT && !fits,
      rovf_ff && rnum_ff == 32'sd0 && rden_ff == 31'd1)

endmodule

`default_nettype wire

@@ design/rau_ctrl.sv @@
// Sequencer of the rational arithmetic unit: one-hot state machine that
// issues datapath operations and owns the handshakes. Uses rau_pkg.
`default_nettype none

module rau_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output rau_pkg::dp_cmd_type       cmd,
   input  wire rau_pkg::dp_stat_type stat
);

`include "rational_arithmetic_unit_assert.svh"

   typedef enum logic [14:0] {
      S_IDLE      = 15'h0001,
      S_GCD_A     = 15'h0002,
      S_DIV_NA    = 15'h0004,
      S_DIV_DA    = 15'h0008,
      S_GCD_B     = 15'h0010,
      S_DIV_NB    = 15'h0020,
      S_DIV_DB    = 15'h0040,
      S_MUL_PROD  = 15'h0080,
      S_GCD_DEN   = 15'h0100,
      S_DIV_QA    = 15'h0200,
      S_DIV_QB    = 15'h0400,
      S_MUL_XY    = 15'h0800,
      S_MUL_LCD   = 15'h1000,
      S_ADDSUB    = 15'h2000,
      S_OUT       = 15'h4000
   } state_type;

   state_type state_ff, state_in, next_step;
   logic      issued_ff, issued_in;
   logic      final_ff, final_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;
   // The load beat leaves one done pulse that must not advance the first gcd state.
   logic      pending_load, pending_load_in;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      case (state_ff)
         S_GCD_A:    next_step = S_DIV_NA;
         S_DIV_NA:   next_step = S_DIV_DA;
         S_DIV_DA:   next_step = final_ff ? S_OUT : S_GCD_B;
         S_GCD_B:    next_step = S_DIV_NB;
         S_DIV_NB:   next_step = S_DIV_DB;
         S_DIV_DB: begin
            if (stat.command == rau_pkg::CMD_ADD || stat.command == rau_pkg::CMD_SUB) begin
               next_step = S_GCD_DEN;
            end else if (stat.command == rau_pkg::CMD_MUL ||
                         stat.command == rau_pkg::CMD_DIV) begin
               next_step = S_MUL_PROD;
            end else begin
               next_step = S_OUT;
            end
         end
         S_GCD_DEN:  next_step = S_DIV_QA;
         S_DIV_QA:   next_step = S_DIV_QB;
         S_DIV_QB:   next_step = S_MUL_XY;
         S_MUL_XY:   next_step = S_MUL_LCD;
         S_MUL_LCD:  next_step = S_ADDSUB;
         S_MUL_PROD: next_step = S_GCD_A;
         S_ADDSUB:   next_step = S_GCD_A;
         default:    next_step = S_IDLE;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      issued_in = issued_ff;
      final_in = final_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd.op = rau_pkg::OP_NONE;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.op = rau_pkg::OP_LOAD;
               final_in = 1'b0;
               issued_in = 1'b1;
               state_in = S_GCD_A;
            end
         end
         S_OUT: begin
            if (slot_free) begin
               cmd.op = rau_pkg::OP_OUT;
               rsp_valid_in = 1'b1;
               state_in = S_IDLE;
               issued_in = 1'b0;
            end
         end
         default: begin
            // The load beat's done pulse is absorbed here before the first issue.
            if (issued_ff) begin
               if (stat.done) begin
                  issued_in = 1'b0;
               end
            end else begin
               issued_in = 1'b1;
               case (state_ff)
                  S_GCD_A:    cmd.op = rau_pkg::OP_GCD_A;
                  S_DIV_NA:   cmd.op = rau_pkg::OP_DIV_N0;
                  S_DIV_DA:   cmd.op = rau_pkg::OP_DIV_D0;
                  S_GCD_B:    cmd.op = rau_pkg::OP_GCD_B;
                  S_DIV_NB:   cmd.op = rau_pkg::OP_DIV_N1;
                  S_DIV_DB:   cmd.op = rau_pkg::OP_DIV_D1;
                  S_MUL_PROD: cmd.op = rau_pkg::OP_MUL_PROD;
                  S_GCD_DEN:  cmd.op = rau_pkg::OP_GCD_DEN;
                  S_DIV_QA:   cmd.op = rau_pkg::OP_DIV_D0;
                  S_DIV_QB:   cmd.op = rau_pkg::OP_DIV_T;
                  S_MUL_XY:   cmd.op = rau_pkg::OP_MUL_XY;
                  S_MUL_LCD:  cmd.op = rau_pkg::OP_MUL_LCD;
                  S_ADDSUB:   cmd.op = rau_pkg::OP_ADDSUB;
                  default:    cmd.op = rau_pkg::OP_NONE;
               endcase
            end
            if (issued_ff && stat.done && !(state_ff == S_GCD_A && !final_ff && pending_load)) begin
               state_in = next_step;
               if (next_step == S_GCD_A) begin
                  final_in = 1'b1;
               end
            end
         end
      endcase
   end

   assign pending_load_in = (state_ff == S_IDLE && req_valid) ? 1'b1 :
                            (stat.done ? 1'b0 : pending_load);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         issued_ff    <= 1'b0;
         final_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pending_load <= 1'b0;
      end else begin
         state_ff     <= state_in;
         issued_ff    <= pending_load ? 1'b0 : issued_in;
         final_ff     <= final_in;
         rsp_valid_ff <= rsp_valid_in;
         pending_load <= pending_load_in;
      end
   end

   `RAU_ASSERT_NEXT(a_accept_busy, clock, reset, req_valid && req_ready, !req_ready)
   `RAU_ASSERT_IMPL(a_out_slot, clock, reset, cmd.op == rau_pkg::OP_OUT, slot_free)
   `RAU_ASSERT_NEXT(a_out_valid, clock, reset, cmd.op == rau_pkg::OP_OUT,
      rsp_valid_ff && req_ready)

endmodule

`default_nettype wire

@@ design/rational_arithmetic_unit.sv @@
// Channel   Ports                                   Direction
// req       req_valid/ready, command, a/b num/den   in
// rsp       rsp_valid/ready, res_num, res_den, ovf  out
// An item takes three fraction reductions (two for normalize), each a binary gcd of
// single steps plus two divisions through the one shared restoring divider. Add and
// subtract add one more gcd and two divisions. The next beat is taken once the result
// sits in the output register; a stalled rsp holds that register. Reset is synchronous
// and clears the sequencer and the datapath busy flags. Uses rau_pkg, rau_ctrl and rau_dp.
`default_nettype none

module rational_arithmetic_unit #(
   parameter int WIDTH = 32
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [2:0]         req_command,
   input  wire logic signed [31:0] req_a_num,
   input  wire logic signed [31:0] req_a_den,
   input  wire logic signed [31:0] req_b_num,
   input  wire logic signed [31:0] req_b_den,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic signed [31:0]      rsp_res_num,
   output logic [30:0]             rsp_res_den,
   output logic                    rsp_overflow
);

   rau_pkg::dp_cmd_type  cmd;
   rau_pkg::dp_stat_type stat;

   rau_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   rau_dp #(
      .WIDTH (WIDTH)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .stat         (stat),
      .req_command  (req_command),
      .req_a_num    (req_a_num),
      .req_a_den    (req_a_den),
      .req_b_num    (req_b_num),
      .req_b_den    (req_b_den),
      .rsp_res_num  (rsp_res_num),
      .rsp_res_den  (rsp_res_den),
      .rsp_overflow (rsp_overflow)
   );

endmodule

`default_nettype wire

@@ sim/rau_checker.sv @@
// Checker for the rational arithmetic unit: predicts each result from the request beats
// and compares it with the response beats. Uses rau_pkg.
`default_nettype none

module rau_checker (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   input  wire logic               req_ready,
   input  wire logic [2:0]         req_command,
   input  wire logic signed [31:0] req_a_num,
   input  wire logic signed [31:0] req_a_den,
   input  wire logic signed [31:0] req_b_num,
   input  wire logic signed [31:0] req_b_den,
   input  wire logic               rsp_valid,
   input  wire logic               rsp_ready,
   input  wire logic signed [31:0] rsp_res_num,
   input  wire logic [30:0]        rsp_res_den,
   input  wire logic               rsp_overflow,
   output int                      fail_count,
   output int                      pending_count
);

   typedef struct {
      logic        neg;
      logic [63:0] num;
      logic [63:0] den;
   } frac_type;

   typedef struct {
      logic signed [31:0] num;
      logic [30:0]        den;
      logic               ovf;
   } quotient_type;

   quotient_type expected_q[$];

   function automatic logic [63:0] euclid(logic [63:0] x, logic [63:0] y);
      logic [63:0] r;
      while (y != 0) begin
         r = x % y;
         x = y;
         y = r;
      end
      return x;
   endfunction

   function automatic frac_type reduce(logic neg, logic [63:0] num, logic [63:0] den);
      frac_type f;
      logic [63:0] g;
      if (num == 0 || den == 0) begin
         f.neg = 0; f.num = 0; f.den = 1;
      end else begin
         g = euclid(num, den);
         f.neg = neg; f.num = num / g; f.den = den / g;
      end
      return f;
   endfunction

   function automatic frac_type load_frac(logic signed [31:0] n, logic signed [31:0] d);
      logic [63:0] nm, dm;
      nm = n[31] ? 64'(-64'(n)) : 64'(n);
      dm = d[31] ? 64'(-64'(d)) : 64'(d);
      return reduce(n[31] != d[31], nm, dm);
   endfunction

   function automatic frac_type sum_frac(frac_type a, frac_type b, logic negate_b);
      logic [63:0] g, lcd, x, y, mag;
      logic bneg, neg;
      g = euclid(a.den, b.den);
      lcd = (a.den / g) * b.den;
      x = a.num * (lcd / a.den);
      y = b.num * (lcd / b.den);
      bneg = negate_b ? !b.neg : b.neg;
      if (a.neg == bneg) begin
         mag = x + y; neg = a.neg;
      end else if (x >= y) begin
         mag = x - y; neg = a.neg;
      end else begin
         mag = y - x; neg = bneg;
      end
      return reduce(neg, mag, lcd);
   endfunction

   function automatic quotient_type predict_fraction(logic [2:0] cmd, logic signed [31:0] an,
         logic signed [31:0] ad, logic signed [31:0] bn, logic signed [31:0] bd);
      frac_type a, b, r;
      quotient_type q;
      logic [63:0] den_lim, num_lim;
      a = load_frac(an, ad);
      b = load_frac(bn, bd);
      case (cmd)
         rau_pkg::CMD_ADD: r = sum_frac(a, b, 1'b0);
         rau_pkg::CMD_SUB: r = sum_frac(a, b, 1'b1);
         rau_pkg::CMD_MUL: r = reduce(a.neg != b.neg, a.num * b.num, a.den * b.den);
         rau_pkg::CMD_DIV: r = reduce(a.neg != b.neg, a.num * b.den, a.den * b.num);
         default: r = reduce(a.neg, a.num, a.den);
      endcase
      den_lim = 64'h7FFF_FFFF;
      num_lim = r.neg ? 64'h8000_0000 : den_lim;
      q.ovf = !(r.num <= num_lim && r.den <= den_lim);
      if (q.ovf) begin
         r.neg = 0; r.num = 0; r.den = 1;
      end
      q.num = r.neg ? 32'(-r.num) : r.num[31:0];
      q.den = r.den[30:0];
      return q;
   endfunction

   assign pending_count = expected_q.size();

   always @(posedge clock) begin
      quotient_type q;
      if (reset) begin
         fail_count <= 0;
         expected_q.delete();
      end else begin
         if (req_valid && req_ready)
            expected_q.push_back(predict_fraction(req_command, req_a_num, req_a_den,
                                                  req_b_num, req_b_den));
         if (rsp_valid && rsp_ready) begin
            if (expected_q.size() == 0) begin
               $error("response beat with no request outstanding");
               fail_count <= fail_count + 1;
            end else begin
               q = expected_q.pop_front();
               if (rsp_res_num !== q.num || rsp_res_den !== q.den
                     || rsp_overflow !== q.ovf) begin
                  if (rsp_res_num !== q.num)
                     $error("res_num expected %0d actual %0d", q.num, rsp_res_num);
                  if (rsp_res_den !== q.den)
                     $error("res_den expected %0d actual %0d", q.den, rsp_res_den);
                  if (rsp_overflow !== q.ovf)
                     $error("overflow expected %0d actual %0d", q.ovf, rsp_overflow);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end
endmodule

`default_nettype wire

@@ sim/tb_rational_arithmetic_unit.sv @@
// Testbench top for the rational arithmetic unit: drives request beats with random gaps
// and response stalls, and gives the verdict. Uses rau_pkg, rau_checker and the RTL.
`default_nettype none

module tb_rational_arithmetic_unit;

   localparam int RANDOM_ITEMS = 750;
   localparam int STALL_LIMIT  = 20000;
   localparam logic [2:0] CMD_NORM = 3'd4;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_ready;
   logic [2:0] req_command = '0;
   logic signed [31:0] req_a_num = '0, req_a_den = '0, req_b_num = '0, req_b_den = '0;
   logic rsp_valid;
   logic rsp_ready = 0;
   logic signed [31:0] rsp_res_num;
   logic [30:0] rsp_res_den;
   logic rsp_overflow;
   int fail_count, pending_count;
   int send_idle_pct = 7, recv_idle_pct = 47;
   int quiet_cycles = 0;

   always #6 clock = ~clock;

   rational_arithmetic_unit dut (.*);

   rau_checker checker_i (.*);

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > STALL_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   function automatic logic [31:0] rand_field();
      case ($urandom_range(5))
         0: return 32'($signed($urandom_range(32)) - 16);
         1: return {$urandom_range(1) ? 16'hFFFF : 16'h0, 16'($urandom)};
         2: return 32'($urandom_range(4000)) * 32'($urandom_range(1, 3) * 6);
         3: return $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   // Presents one beat and holds it until the block takes it; valid stays high after.
   task automatic send_beat(logic [2:0] cmd, logic [31:0] an, logic [31:0] ad,
                            logic [31:0] bn, logic [31:0] bd);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1; req_command <= cmd;
      req_a_num <= an; req_a_den <= ad; req_b_num <= bn; req_b_den <= bd;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic send_random(int n);
      for (int i = 0; i < n; i++)
         send_beat(3'($urandom_range(7)), rand_field(), rand_field(), rand_field(),
                   rand_field());
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // Directed: every command, zeros, division by zero, sign moves, extremes.
      for (int c = 0; c < 8; c++) send_beat(3'(c), 6, -4, -10, 15);
      send_beat(rau_pkg::CMD_ADD, 0, 5, 3, 0);
      send_beat(rau_pkg::CMD_DIV, 3, 7, 0, 9);
      send_beat(rau_pkg::CMD_MUL, 32'h8000_0000, -1, 1, 1);
      send_beat(CMD_NORM, 1, 32'h8000_0000, 0, 0);
      send_beat(CMD_NORM, -1, 32'h8000_0000, 0, 0);
      send_beat(rau_pkg::CMD_MUL, 32'h7FFF_FFFF, 1, 32'h7FFF_FFFF, 1);
      send_beat(rau_pkg::CMD_SUB, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                32'h8000_0000);
      send_beat(rau_pkg::CMD_ADD, 1, 32'h7FFF_FFFF, 1, 32'h7FFF_FFFE);
      send_beat(rau_pkg::CMD_DIV, 32'h8000_0000, 32'h8000_0000, -1, -1);
      send_beat(rau_pkg::CMD_SUB, 5, 3, 5, 3);
      send_beat(rau_pkg::CMD_ADD, -32'sd1, 32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA);
      // The sender holds off until every outstanding result is back.
      req_valid <= 0;
      @(posedge clock);
      wait (pending_count == 0);
      send_random(RANDOM_ITEMS / 3);
      send_idle_pct = 47; recv_idle_pct = 7;
      send_random(RANDOM_ITEMS / 3);
      send_idle_pct = 0; recv_idle_pct = 0;
      send_random(RANDOM_ITEMS / 3);
      req_valid <= 0;
      @(posedge clock);
      wait (pending_count == 0);
      repeat (50) @(posedge clock);
      if (fail_count == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end
endmodule

`default_nettype wire
